// ===== hw/rtl/rlm_pkg.sv =====
// Shared types and constants for the RMS level meter.
package rlm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 17;
    localparam int Y_W        = 48;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = 32;
    localparam int LEVEL_W    = 7;
    localparam int FMT_W      = 2;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [FMT_W-1:0] FMT_UBYTE = 2'd0;
    localparam logic [FMT_W-1:0] FMT_SBYTE = 2'd1;
    localparam logic [FMT_W-1:0] FMT_WORD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    localparam logic [LEN_W-1:0] WARMUP_RESET = 16'd2000;
    localparam logic [LEN_W-1:0] WINDOW_RESET = 16'd12000;

    // first trial bit of the root: 2^40
    localparam logic [SUM_W-1:0] SQRT_TOP = SUM_W'(1) << 40;
    localparam int FULL_SCALE_SHIFT = 15;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [LEN_W-1:0] warmup;
        logic [LEN_W-1:0] window;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] window;
    } t_qentry;

endpackage

// ===== hw/rtl/rlm_ifs.sv =====
// Valid/ready channel interfaces for sample input, level output and config writes.
interface rlm_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlm_pkg::SAMPLE_W-1:0]  sample_word;
    logic                          restart;
    modport source (output valid, output sample_word, output restart, input ready);
    modport sink   (input valid, input sample_word, input restart, output ready);
endinterface

interface rlm_out_if;
    logic                          valid;
    logic                          ready;
    logic [rlm_pkg::LEVEL_W-1:0]   level_percent;
    modport source (output valid, output level_percent, input ready);
    modport sink   (input valid, input level_percent, output ready);
endinterface

interface rlm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rlm_pkg::CFG_IDX_W-1:0]  index;
    logic [rlm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rlm_front.sv =====
// Front end: format conversion, DC blocker, squaring and window accumulation.
module rlm_front #(
    parameter int QUEUE_DEPTH = rlm_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rlm_in_if.sink                            i_in,
    input  rlm_pkg::t_cfg                     i_cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_q_count,
    output logic                              o_push,
    output rlm_pkg::t_qentry                  o_entry
);
    import rlm_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int FB_W  = Y_W + 18;

    // filter and position state
    logic signed [SAMPLE_W-1:0] r_x1, n_x1;
    logic signed [Y_W-1:0]      r_y1, n_y1;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [SUM_W-1:0]           r_sum, n_sum;

    // stage A: clamped filter output
    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_o, n_a_o;
    logic                       r_a_acc, n_a_acc;
    logic                       r_a_last, n_a_last;
    logic                       r_a_clr;

    // stage B: square
    logic                       r_b_valid;
    logic [SQ_W-1:0]            r_b_sq;
    logic                       r_b_acc;
    logic                       r_b_last;
    logic                       r_b_clr;

    logic                       accept;
    logic [CNT_W:0]             inflight;
    logic signed [SAMPLE_W-1:0] s;
    logic [LEN_W-1:0]           win_eff;
    logic [POS_W-1:0]           pos_eff;
    logic [POS_W-1:0]           last_pos;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [FB_W-1:0]     y1_ext;
    logic signed [FB_W-1:0]     fb_prod;
    logic signed [Y_W-1:0]      y;
    logic signed [SQ_W-1:0]     o_wide;
    logic signed [SQ_W-1:0]     sq_signed;
    logic [SUM_W-1:0]           sum_base;

    // credit: every window end still in flight needs a queue slot
    assign inflight = {1'b0, i_q_count} + (CNT_W+1)'(r_a_valid & r_a_last)
                      + (CNT_W+1)'(r_b_valid & r_b_last);
    assign i_in.ready = inflight < (CNT_W+1)'(QUEUE_DEPTH);
    assign accept     = i_in.valid & i_in.ready;

    always_comb begin
        unique case (i_cfg.fmt)
            FMT_UBYTE: s = {~i_in.sample_word[7], i_in.sample_word[6:0], 8'h00};
            FMT_SBYTE: s = {i_in.sample_word[7:0], 8'h00};
            default:   s = i_in.sample_word;
        endcase
    end

    assign win_eff  = (i_cfg.window == '0) ? LEN_W'(1) : i_cfg.window;
    assign pos_eff  = i_in.restart ? '0 : r_pos;
    assign last_pos = {1'b0, i_cfg.warmup} + {1'b0, win_eff} - POS_W'(1);

    always_comb begin
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_pos    = r_pos;
        diff     = $signed({s[SAMPLE_W-1], s})
                   - (i_in.restart ? '0 : $signed({r_x1[SAMPLE_W-1], r_x1}));
        y1_ext   = i_in.restart ? '0 : FB_W'(r_y1);
        // 65500 = 2^16 - 2^5 - 2^2
        fb_prod  = (y1_ext <<< 16) - (y1_ext <<< 5) - (y1_ext <<< 2);
        y        = fb_prod[Y_W+15:16]
                   + $signed({{(Y_W-SAMPLE_W-17){diff[SAMPLE_W]}}, diff, 16'h0000});
        o_wide   = y[Y_W-1:16];
        n_a_o    = o_wide[SAMPLE_W-1:0];
        if (o_wide > SQ_W'(32767)) begin
            n_a_o = 16'sh7fff;
        end else if (o_wide < -SQ_W'(32768)) begin
            n_a_o = 16'sh8000;
        end
        n_a_acc  = pos_eff >= {1'b0, i_cfg.warmup};
        n_a_last = pos_eff >= last_pos;
        if (accept) begin
            n_x1  = s;
            n_y1  = y;
            n_pos = n_a_last ? '0 : pos_eff + POS_W'(1);
        end
    end

    assign sq_signed = r_a_o * r_a_o;
    assign sum_base  = r_b_clr ? '0 : r_sum;

    always_comb begin
        o_entry.sum    = sum_base + (r_b_acc ? SUM_W'(r_b_sq) : '0);
        o_entry.window = win_eff;
        o_push         = r_b_valid & r_b_last;
        n_sum          = r_sum;
        if (r_b_valid) begin
            n_sum = r_b_last ? '0 : o_entry.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1      <= '0;
            r_y1      <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_x1      <= n_x1;
            r_y1      <= n_y1;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_o    <= n_a_o;
        r_a_acc  <= n_a_acc;
        r_a_last <= n_a_last;
        r_a_clr  <= i_in.restart;
        r_b_sq   <= SQ_W'(sq_signed);
        r_b_acc  <= r_a_acc;
        r_b_last <= r_a_last;
        r_b_clr  <= r_a_clr;
    end

endmodule

// ===== hw/rtl/rlm_queue.sv =====
// Small FIFO of finished window sums between front and back end.
module rlm_queue #(
    parameter int QUEUE_DEPTH = rlm_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  rlm_pkg::t_qentry                  i_entry,
    input  logic                              i_pop,
    output logic                              o_valid,
    output rlm_pkg::t_qentry                  o_entry,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_count
);
    import rlm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qentry          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // front-end credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != CNT_W'(QUEUE_DEPTH))
        else $error("window sum pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/rlm_back.sv =====
// Back end: mean by restoring division, bitwise square root, percent scaling.
module rlm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  rlm_pkg::t_qentry i_q_entry,
    output logic             o_pop,
    rlm_out_if.source        o_out
);
    import rlm_pkg::*;

    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int SCALE_W   = SUM_W + 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SQRT = 4'b0100,
        S_DONE = 4'b1000
    } t_back_state;

    t_back_state          r_state, n_state;
    logic [SUM_W-1:0]     r_dq, n_dq;     // dividend, then quotient, then sqrt residue
    logic [LEN_W:0]       r_rem, n_rem;
    logic [LEN_W-1:0]     r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_root, n_root;
    logic [SUM_W-1:0]     r_bit, n_bit;
    logic                 r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]   r_level, n_level;

    logic [LEN_W:0]       rem_sh;
    logic                 q_bit;
    logic [SUM_W-1:0]     trial;
    logic [SCALE_W-1:0]   root_ext;
    logic [SCALE_W-1:0]   scaled;

    assign rem_sh   = {r_rem[LEN_W-1:0], r_dq[SUM_W-1]};
    assign q_bit    = rem_sh >= {1'b0, r_div};
    assign trial    = r_root + r_bit;
    assign root_ext = SCALE_W'(r_root);
    // r * 100 = r * (64 + 32 + 4)
    assign scaled   = (root_ext << 6) + (root_ext << 5) + (root_ext << 2);

    assign o_out.valid         = r_out_valid;
    assign o_out.level_percent = r_level;

    always_comb begin
        n_state     = r_state;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_root      = r_root;
        n_bit       = r_bit;
        n_level     = r_level;
        n_out_valid = r_out_valid & ~o_out.ready;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_dq    = i_q_entry.sum;
                    n_div   = i_q_entry.window;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = q_bit ? rem_sh - {1'b0, r_div} : rem_sh;
                n_dq  = {r_dq[SUM_W-2:0], q_bit};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    n_root  = '0;
                    n_bit   = SQRT_TOP;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_dq >= trial) begin
                    n_dq   = r_dq - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_level     = scaled[FULL_SCALE_SHIFT +: LEVEL_W];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_cnt   <= n_cnt;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_level <= n_level;
    end

    // division must leave a proper remainder behind
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQRT |-> r_rem < {1'b0, r_div})
        else $error("division remainder not below divisor");

    // a waiting level holds until it is taken
    a_level_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_level))
        else $error("level changed while waiting");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_DIV && r_cnt == '0)
        else $error("popped entry did not start a division");

endmodule

// ===== hw/rtl/rms_level_meter_dc_blocked_core.sv =====
// RMS level meter core: config registers, front end, window queue and back end.
//
// Samples are taken at one per clock unless the queue credit stalls them. Each
// sample is converted per the format register, run through a one-pole DC
// blocker and clamped to 16 bits; after the warm-up count its square is added
// into the window sum. The window's last sample pushes the sum into a
// QUEUE_DEPTH-entry queue and the next sample may follow at once. The back end
// turns each sum into a level, one quotient bit per cycle and then one root bit
// per cycle, so the input stalls only when queued and in-flight window sums
// would fill the queue. Config writes are always ready and take effect in the
// next cycle.
module rms_level_meter_dc_blocked_core #(
    parameter int QUEUE_DEPTH = rlm_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlm_in_if.sink     i_in,
    rlm_out_if.source  o_out,
    rlm_cfg_if.sink    i_cfg
);
    import rlm_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg;
    logic             push;
    logic             pop;
    logic             q_valid;
    t_qentry          push_entry;
    t_qentry          q_entry;
    logic [CNT_W-1:0] q_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt    <= FMT_UBYTE;
            r_cfg.warmup <= WARMUP_RESET;
            r_cfg.window <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FORMAT: r_cfg.fmt    <= i_cfg.data[FMT_W-1:0];
                REG_WARMUP: r_cfg.warmup <= i_cfg.data[LEN_W-1:0];
                REG_WINDOW: r_cfg.window <= i_cfg.data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    rlm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    rlm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    rlm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== dv/rlm_level_checker.sv =====
// Level checker: mirrors the meter's arithmetic and compares every emitted level.
`timescale 1ns / 100ps
module rlm_level_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rlm_in_if    i_in,
    rlm_out_if   i_out,
    rlm_cfg_if   i_cfg,
    output int   o_error_count,
    output int   o_pending
);
    import rlm_pkg::*;

    localparam longint DC_FEEDBACK = 65500;

    t_cfg                       cfg_shadow;
    logic signed [SAMPLE_W-1:0] prev_sample;
    longint                     prev_filtered;
    logic [SUM_W-1:0]           sum_of_squares;
    logic [POS_W-1:0]           position;
    logic [LEVEL_W-1:0]         level_queue[$];
    int                         level_errors = 0;

    // One accepted sample: filter, accumulate, and queue a level at window end.
    task automatic meter_step(input logic [SAMPLE_W-1:0] word, input logic restart);
        logic signed [SAMPLE_W-1:0] s;
        longint                     y;
        longint                     clamped;
        logic [POS_W-1:0]           win;
        logic [POS_W-1:0]           last;
        logic [63:0]                rem;
        logic [63:0]                root;
        logic [63:0]                trial;
        // a zero window counts as one
        win  = (cfg_shadow.window == '0) ? POS_W'(1) : POS_W'(cfg_shadow.window);
        last = POS_W'(cfg_shadow.warmup) + win - 1'b1;
        if (restart) begin
            prev_sample    = '0;
            prev_filtered  = 0;
            sum_of_squares = '0;
            position       = '0;
        end
        case (cfg_shadow.fmt)
            FMT_UBYTE: s = {~word[7], word[6:0], 8'h00};
            FMT_SBYTE: s = {word[7:0], 8'h00};
            default:   s = word;   // format three reads as a 16-bit word too
        endcase
        y = (longint'(s) - longint'(prev_sample)) * 65536
            + ((prev_filtered * DC_FEEDBACK) >>> 16);
        prev_sample   = s;
        prev_filtered = y;
        clamped = y >>> 16;
        if (clamped > 32767) begin
            clamped = 32767;
        end else if (clamped < -32768) begin
            clamped = -32768;
        end
        if (position >= POS_W'(cfg_shadow.warmup)) begin
            sum_of_squares = sum_of_squares + SUM_W'(clamped * clamped);
        end
        // emits once the position reaches or has passed the window's last sample
        if (position >= last) begin
            rem   = 64'(sum_of_squares) / 64'(win);
            root  = '0;
            trial = 64'(SQRT_TOP);
            while (trial > rem) begin
                trial = trial >> 2;
            end
            while (trial != 0) begin
                if (rem >= root + trial) begin
                    rem  = rem - (root + trial);
                    root = (root >> 1) + trial;
                end else begin
                    root = root >> 1;
                end
                trial = trial >> 2;
            end
            level_queue.push_back(LEVEL_W'((root * 100) >> FULL_SCALE_SHIFT));
            sum_of_squares = '0;
            position       = '0;
        end else begin
            position = position + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] want_level;
        if (!i_rst_n) begin
            cfg_shadow     = '{fmt: FMT_UBYTE, warmup: WARMUP_RESET, window: WINDOW_RESET};
            prev_sample    = '0;
            prev_filtered  = 0;
            sum_of_squares = '0;
            position       = '0;
            level_queue.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (level_queue.size() == 0) begin
                    $error("level_percent: no level expected, actual %0d",
                           i_out.level_percent);
                    level_errors++;
                end else begin
                    want_level = level_queue.pop_front();
                    if (i_out.level_percent !== want_level) begin
                        $error("level_percent: expected %0d, actual %0d",
                               want_level, i_out.level_percent);
                        level_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                meter_step(i_in.sample_word, i_in.restart);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_FORMAT: cfg_shadow.fmt    = i_cfg.data[FMT_W-1:0];
                    REG_WARMUP: cfg_shadow.warmup = i_cfg.data[LEN_W-1:0];
                    REG_WINDOW: cfg_shadow.window = i_cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_error_count <= level_errors;
        o_pending     <= level_queue.size();
    end

endmodule

// ===== dv/tb_rms_level_meter_dc_blocked_core.sv =====
// Testbench top: drives samples and register writes into the RMS level meter.
`timescale 1ns / 100ps
module tb_rms_level_meter_dc_blocked_core;
    import rlm_pkg::*;

    localparam int RAND_PHASES    = 11;
    localparam int PHASE_ITEMS    = 80;
    localparam int PRESSURE_ITEMS = 160;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PCT       = 12;
    localparam int NO_IDLE_ITEMS  = 100;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [FMT_W-1:0]     FMT_ALIAS  = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   error_count;
    int   pending;
    bit   idle_on  = 1'b1;
    bit   hold_req = 1'b0;

    rlm_in_if  sample_ch ();
    rlm_out_if level_ch ();
    rlm_cfg_if cfg_ch ();

    rms_level_meter_dc_blocked_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_ch),
        .o_out   (level_ch),
        .i_cfg   (cfg_ch)
    );

    rlm_level_checker level_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (sample_ch),
        .i_out         (level_ch),
        .i_cfg         (cfg_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always #1 clk = ~clk;

    initial begin
        #3_000_000;
        $display("tb_rms_level_meter_dc_blocked_core: FAIL");
        $finish;
    end

    // level receiver: random stalls, plus one long hold-off on request
    initial begin
        level_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                level_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            level_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] word, input logic restart);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_word <= word;
        sample_ch.restart     <= restart;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic configure(input logic [FMT_W-1:0] fmt,
                             input logic [LEN_W-1:0] warmup,
                             input logic [LEN_W-1:0] window);
        write_reg(REG_FORMAT, CFG_DATA_W'(fmt));
        write_reg(REG_WARMUP, warmup);
        write_reg(REG_WINDOW, window);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering, let every expected level land, then let the pipe settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random words with runs of held values (DC) and full-scale steps mixed in
    task automatic stream(input int count);
        logic [SAMPLE_W-1:0] word;
        word = 16'($urandom);
        repeat (count) begin
            case ($urandom_range(9))
                0, 1:    word = word;
                2:       word = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                3:       word = $urandom_range(1) ? 16'h0080 : 16'h007F;
                default: word = 16'($urandom);
            endcase
            send_sample(word, $urandom_range(49) == 0);
        end
    endtask

    initial begin
        logic [LEN_W-1:0] warmup;
        logic [LEN_W-1:0] window;
        sample_ch.valid       <= 1'b0;
        sample_ch.sample_word <= '0;
        sample_ch.restart     <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_FORMAT;
        cfg_ch.data           <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: long warm-up, nothing comes out yet
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFF80, 1'b0);
        send_sample(16'h0000, 1'b0);
        drain();

        // unsigned bytes, one-sample window; position already past the end
        write_reg(REG_UNUSED, 16'hFFFF);
        configure(FMT_UBYTE, 16'd0, 16'd1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'h0080, 1'b0);
        send_sample(16'h007F, 1'b0);
        send_sample(16'hFF00, 1'b1);
        drain();

        // signed bytes, zero window
        configure(FMT_SBYTE, 16'd0, 16'd0);
        send_sample(16'h007F, 1'b0);
        send_sample(16'h0080, 1'b0);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8080, 1'b1);
        drain();

        // full-scale steps drive the filter into the clamp
        configure(FMT_WORD, 16'd1, 16'd2);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        drain();

        configure(FMT_ALIAS, 16'd0, 16'd3);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h1234, 1'b0);
        drain();

        // random settings; long warm-ups or windows leave the position past the
        // next phase's end, so that phase emits on its first sample
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(9))
                0:       warmup = '0;
                1:       warmup = 16'hFFFF;
                default: warmup = LEN_W'($urandom_range(24));
            endcase
            case ($urandom_range(9))
                0:       window = '0;
                1:       window = 16'hFFFF;
                2:       window = 16'd1;
                default: window = LEN_W'($urandom_range(40, 2));
            endcase
            configure(FMT_W'($urandom), warmup, window);
            stream(PHASE_ITEMS);
            drain();
        end

        // a stretch of back-to-back samples with no idling on either side
        idle_on = 1'b0;
        configure(FMT_WORD, 16'd5, 16'd30);
        send_sample(16'($urandom), 1'b1);
        repeat (NO_IDLE_ITEMS - 1) send_sample(16'($urandom), 1'b0);
        drain();
        idle_on = 1'b1;

        // a level per sample while the receiver holds off: the queue fills
        configure(FMT_SBYTE, 16'd0, 16'd1);
        hold_req = 1'b1;
        stream(PRESSURE_ITEMS);
        drain();

        if (error_count == 0) begin
            $display("tb_rms_level_meter_dc_blocked_core: PASS");
        end else begin
            $display("tb_rms_level_meter_dc_blocked_core: FAIL");
        end
        $finish;
    end

endmodule
